>>> rtl/udw_pkg.sv
// ----------------------------------------------------------------------------
// udw_pkg
// Shared types, constants and the column width lookup for the UTF-8 display
// width decoder.
// ----------------------------------------------------------------------------
package udw_pkg;

  localparam int CP_W             = 21;
  localparam int RUN_W            = 16;
  localparam int TOTAL_WIDTH_DEF  = 16;
  localparam int QUEUE_DEPTH      = 4;
  localparam int REPL_CNT_W       = 3;

  localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

  // one queue entry: all results caused by one byte
  // replacements come first, then the decoded code point if any
  typedef struct packed {
    logic [REPL_CNT_W-1:0] n_repl;
    logic                  cp_vld;
    logic [CP_W-1:0]       cp;
    logic [1:0]            cp_w;
    logic                  eos;
  } udw_entry_t;

  function automatic logic in_rng(input logic [CP_W-1:0] r,
                                  input logic [CP_W-1:0] lo,
                                  input logic [CP_W-1:0] hi);
    return (r >= lo) && (r <= hi);
  endfunction

  function automatic logic [1:0] cp_col_width(input logic [CP_W-1:0] r);
    logic comb;
    logic wide;
    comb = in_rng(r, 21'h000300, 21'h00036F) || in_rng(r, 21'h001AB0, 21'h001AFF) ||
           in_rng(r, 21'h001DC0, 21'h001DFF) || in_rng(r, 21'h0020D0, 21'h0020FF) ||
           in_rng(r, 21'h00FE20, 21'h00FE2F);
    wide = in_rng(r, 21'h001100, 21'h00115F) || (r == 21'h002329) || (r == 21'h00232A) ||
           (in_rng(r, 21'h002E80, 21'h00A4CF) && (r != 21'h00303F)) ||
           in_rng(r, 21'h00AC00, 21'h00D7A3) || in_rng(r, 21'h00F900, 21'h00FAFF) ||
           in_rng(r, 21'h00FE30, 21'h00FE6F) || in_rng(r, 21'h00FF00, 21'h00FF60) ||
           in_rng(r, 21'h00FFE0, 21'h00FFE6) || in_rng(r, 21'h01F300, 21'h01F64F) ||
           in_rng(r, 21'h01F900, 21'h01F9FF) || in_rng(r, 21'h020000, 21'h03FFFD);
    if ((r == '0) || comb) begin
      return 2'd0;
    end else if (wide) begin
      return 2'd2;
    end else begin
      return 2'd1;
    end
  endfunction

endpackage

>>> rtl/udw_front.sv
// ----------------------------------------------------------------------------
// udw_front
// Takes one byte per cycle while the queue is not full, tracks the open UTF-8
// sequence and writes one queue entry per byte that produces results.
// ----------------------------------------------------------------------------
module udw_front
  import udw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_string,
  input  logic        q_full,
  output logic        q_push,
  output udw_entry_t  q_entry
);

  logic [CP_W-1:0]       part_r, part_nxt;
  logic [1:0]            exp_r, exp_nxt;
  logic [1:0]            taken_r, taken_nxt;

  logic                  accept;
  logic                  is_cont;
  logic [CP_W-1:0]       acc;
  logic [1:0]            exp_dec;
  logic [REPL_CNT_W-1:0] n_repl;
  logic                  cp_vld;
  logic [CP_W-1:0]       cp;

  assign accept  = in_push && !q_full;
  assign is_cont = (in_text_byte[7:6] == 2'b10);
  assign acc     = {part_r[CP_W-7:0], in_text_byte[5:0]};
  assign exp_dec = exp_r - 2'd1;

  always_comb begin
    part_nxt  = part_r;
    exp_nxt   = exp_r;
    taken_nxt = taken_r;
    n_repl    = '0;
    cp_vld    = 1'b0;
    cp        = acc;
    if ((exp_r != 2'd0) && is_cont) begin
      if (exp_dec == 2'd0) begin
        cp_vld    = 1'b1;
        part_nxt  = '0;
        exp_nxt   = 2'd0;
        taken_nxt = 2'd0;
      end else begin
        part_nxt  = acc;
        exp_nxt   = exp_dec;
        taken_nxt = taken_r + 2'd1;
      end
    end else begin
      // broken sequence: lead plus each continuation taken
      if (exp_r != 2'd0) begin
        n_repl = REPL_CNT_W'(taken_r) + REPL_CNT_W'(1);
      end
      taken_nxt = 2'd0;
      exp_nxt   = 2'd0;
      part_nxt  = '0;
      if (in_text_byte[7] == 1'b0) begin
        cp_vld = 1'b1;
        cp     = CP_W'(in_text_byte);
      end else if (in_text_byte[7:5] == 3'b110) begin
        exp_nxt  = 2'd1;
        part_nxt = CP_W'(in_text_byte[4:0]);
      end else if (in_text_byte[7:4] == 4'b1110) begin
        exp_nxt  = 2'd2;
        part_nxt = CP_W'(in_text_byte[3:0]);
      end else if (in_text_byte[7:3] == 5'b11110) begin
        exp_nxt  = 2'd3;
        part_nxt = CP_W'(in_text_byte[2:0]);
      end else begin
        n_repl = n_repl + REPL_CNT_W'(1);
      end
    end
    // sequence cut off at the end of the string
    if (in_end_of_string && (exp_nxt != 2'd0)) begin
      n_repl = n_repl + REPL_CNT_W'(taken_nxt) + REPL_CNT_W'(1);
    end
    if (in_end_of_string) begin
      part_nxt  = '0;
      exp_nxt   = 2'd0;
      taken_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r  <= '0;
      exp_r   <= 2'd0;
      taken_r <= 2'd0;
    end else if (accept) begin
      part_r  <= part_nxt;
      exp_r   <= exp_nxt;
      taken_r <= taken_nxt;
    end
  end

  assign q_push         = accept && ((n_repl != '0) || cp_vld);
  assign q_entry.n_repl = n_repl;
  assign q_entry.cp_vld = cp_vld;
  assign q_entry.cp     = cp;
  assign q_entry.cp_w   = cp_col_width(cp);
  assign q_entry.eos    = in_end_of_string;

endmodule

>>> rtl/udw_queue.sv
// ----------------------------------------------------------------------------
// udw_queue
// Small register queue of decoded entries between the front and back parts.
// ----------------------------------------------------------------------------
module udw_queue
  import udw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  udw_entry_t  wr_entry,
  input  logic        pop,
  output udw_entry_t  head,
  output logic        full,
  output logic        empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  udw_entry_t         store_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]     cnt_r, cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign full    = (cnt_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (PTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

>>> rtl/udw_back.sv
// ----------------------------------------------------------------------------
// udw_back
// Expands each queue entry into its results, one per cycle unless stalled
// by out_pop, keeps the saturating width total, holds the output register.
// ----------------------------------------------------------------------------
module udw_back
  import udw_pkg::*;
#(
  parameter int TOTAL_WIDTH_BITS = TOTAL_WIDTH_DEF
)(
  input  logic             clk,
  input  logic             rst_n,
  input  udw_entry_t       head,
  input  logic             q_empty,
  output logic             q_pop,
  input  logic             out_pop,
  output logic             out_empty,
  output logic [CP_W-1:0]  out_code_point,
  output logic [1:0]       out_column_width,
  output logic             out_was_replaced,
  output logic [RUN_W-1:0] out_running_width,
  output logic             out_last_of_item,
  output logic             out_last_of_string
);

  localparam int TW = TOTAL_WIDTH_BITS;

  logic [REPL_CNT_W-1:0] idx_r, idx_nxt;
  logic [TW-1:0]         tot_r, tot_nxt;
  logic                  ovld_r, ovld_nxt;

  logic [CP_W-1:0]       cp_r;
  logic [1:0]            w_r;
  logic                  repl_r;
  logic [RUN_W-1:0]      run_r;
  logic                  last_item_r;
  logic                  last_str_r;

  logic                  advance;
  logic                  is_repl;
  logic [CP_W-1:0]       res_cp;
  logic [1:0]            res_w;
  logic [REPL_CNT_W-1:0] n_tot;
  logic                  last;
  logic [TW:0]           sum;
  logic [TW-1:0]         sat;
  logic [RUN_W-1:0]      run_val;

  assign advance = !q_empty && (!ovld_r || out_pop);
  assign is_repl = (idx_r < head.n_repl);
  assign res_cp  = is_repl ? REPL_CP : head.cp;
  assign res_w   = is_repl ? 2'd1 : head.cp_w;
  assign n_tot   = head.n_repl + REPL_CNT_W'(head.cp_vld);
  assign last    = ((idx_r + REPL_CNT_W'(1)) == n_tot);
  assign sum     = {1'b0, tot_r} + (TW+1)'(res_w);
  assign sat     = sum[TW] ? '1 : sum[TW-1:0];
  assign q_pop   = advance && last;

  generate
    if (TW > RUN_W) begin : g_clip
      assign run_val = (|sat[TW-1:RUN_W]) ? '1 : sat[RUN_W-1:0];
    end else begin : g_ext
      assign run_val = RUN_W'(sat);
    end
  endgenerate

  always_comb begin
    idx_nxt  = idx_r;
    tot_nxt  = tot_r;
    ovld_nxt = ovld_r;
    if (out_pop && ovld_r) begin
      ovld_nxt = 1'b0;
    end
    if (advance) begin
      ovld_nxt = 1'b1;
      idx_nxt  = last ? '0 : idx_r + REPL_CNT_W'(1);
      // total clears once the string's final result is out
      tot_nxt  = (last && head.eos) ? '0 : sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      tot_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      tot_r  <= tot_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cp_r        <= res_cp;
      w_r         <= res_w;
      repl_r      <= is_repl;
      run_r       <= run_val;
      last_item_r <= last;
      last_str_r  <= last && head.eos;
    end
  end

  assign out_empty          = !ovld_r;
  assign out_code_point     = cp_r;
  assign out_column_width   = w_r;
  assign out_was_replaced   = repl_r;
  assign out_running_width  = run_r;
  assign out_last_of_item   = last_item_r;
  assign out_last_of_string = last_str_r;

endmodule

>>> rtl/utf8_display_width_top.sv
// ----------------------------------------------------------------------------
// utf8_display_width_top
// UTF-8 decoder with terminal column width and a per-string running total.
// Accepts one byte per cycle unless in_full; a byte's first result passes the
// queue, then the output register. The result stage emits one result per cycle
// unless held by out_pop; a byte has 0 to 4 results; bytes with none skip it.
// Synchronous reset clears the open sequence, the queue, the total and the
// output register.
// ----------------------------------------------------------------------------
module utf8_display_width_top
  import udw_pkg::*;
#(
  parameter int TOTAL_WIDTH_BITS = TOTAL_WIDTH_DEF
)(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic [7:0]       in_text_byte,
  input  logic             in_end_of_string,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [CP_W-1:0]  out_code_point,
  output logic [1:0]       out_column_width,
  output logic             out_was_replaced,
  output logic [RUN_W-1:0] out_running_width,
  output logic             out_last_of_item,
  output logic             out_last_of_string
);

  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  udw_entry_t q_wr;
  udw_entry_t q_head;

  assign in_full = q_full;

  udw_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_text_byte     (in_text_byte),
    .in_end_of_string (in_end_of_string),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_entry          (q_wr)
  );

  udw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  udw_back #(
    .TOTAL_WIDTH_BITS (TOTAL_WIDTH_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (q_head),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .out_pop            (out_pop),
    .out_empty          (out_empty),
    .out_code_point     (out_code_point),
    .out_column_width   (out_column_width),
    .out_was_replaced   (out_was_replaced),
    .out_running_width  (out_running_width),
    .out_last_of_item   (out_last_of_item),
    .out_last_of_string (out_last_of_string)
  );

endmodule
